// File: hw/rtl/interval_timing_statistics_defines.svh
// Assertion macros used by the checker file its_checker.sv.
`ifndef INTERVAL_TIMING_STATISTICS_DEFINES_SVH
`define INTERVAL_TIMING_STATISTICS_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ITS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ITS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/its_pkg.sv
// ----------------------------------------------------------------------------
// its_pkg
// Types and codes shared by the interval timing statistics block.
// ----------------------------------------------------------------------------
package its_pkg;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 56;
  localparam int STAT_W   = 48;

  localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BEGIN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_END   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RECORD    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic              load_in;    // capture the input item
    logic              rd;         // read slot at addr
    logic              upd_end;    // write back end statistics
    logic              wr_begin;   // write stamp (and clear if new)
    logic              clr;        // clear slot after report read
    logic              div_start;  // start the average divider
    logic              set_res;    // latch result with given status
    logic [STATUS_W-1:0] res_status;
    logic              res_last;
    logic              use_walk;   // address from the report walk counter
  } its_cmd_t;

  typedef struct packed {
    logic div_done;
  } its_sts_t;
endpackage

// File: hw/rtl/its_in_if.sv
// ----------------------------------------------------------------------------
// its_in_if
// Input channel: valid/ready with the event payload.
// ----------------------------------------------------------------------------
interface its_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] slot;
  logic [47:0] time_now;
  modport source(output valid, kind, slot, time_now, input ready);
  modport sink(input valid, kind, slot, time_now, output ready);
endinterface

// File: hw/rtl/its_out_if.sv
// ----------------------------------------------------------------------------
// its_out_if
// Output channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface its_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot_out;
  logic [31:0] interval_count;
  logic [55:0] total_ns;
  logic [47:0] min_ns;
  logic [47:0] max_ns;
  logic [55:0] avg_ns;
  logic        last;
  modport source(output valid, status, slot_out, interval_count, total_ns, min_ns,
                 max_ns, avg_ns, last, input ready);
  modport sink(input valid, status, slot_out, interval_count, total_ns, min_ns,
               max_ns, avg_ns, last, output ready);
endinterface

// File: hw/rtl/its_ram.sv
// ----------------------------------------------------------------------------
// its_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module its_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/its_div.sv
// ----------------------------------------------------------------------------
// its_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module its_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [31:0] divisor,
  output logic [55:0] quotient,
  output logic        done
);
  logic [55:0] q;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [31:0] dsr;

  assign trial = {rem[31:0], q[55]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[54:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[55]};
          q   <= {q[54:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (dsr == '0) ? '0 : q;
endmodule

// File: hw/rtl/its_datapath.sv
// ----------------------------------------------------------------------------
// its_datapath
// Slot stores, interval update arithmetic, divider and result register.
// ----------------------------------------------------------------------------
module its_datapath #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  its_pkg::its_cmd_t   cmd,
  output its_pkg::its_sts_t   sts,
  input  logic [5:0]          in_slot,
  input  logic [47:0]         in_time,
  input  logic                new_slot,
  input  logic [5:0]          walk,
  output logic [2:0]          res_status,
  output logic [5:0]          res_slot,
  output logic [31:0]         res_count,
  output logic [55:0]         res_total,
  output logic [47:0]         res_min,
  output logic [47:0]         res_max,
  output logic [55:0]         res_avg,
  output logic                res_last
);
  import its_pkg::*;
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW = (TIME_BITS < 48) ? TIME_BITS : 48;
  localparam logic [TOTAL_W-1:0] TOT_MAX = '1;
  localparam logic [COUNT_W-1:0] CNT_MAX = '1;

  logic [5:0]  slot_q;
  logic [47:0] now_q;
  logic [AW-1:0] addr;
  logic [47:0] stamp_rd, min_rd, max_rd;
  logic [55:0] tot_rd;
  logic [31:0] cnt_rd;
  logic [47:0] iv;
  logic [56:0] sum;
  logic        we_stamp, we_stat;
  logic [47:0] stamp_wd, min_wd, max_wd;
  logic [55:0] tot_wd;
  logic [31:0] cnt_wd;
  logic [55:0] quo;
  logic        div_done;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      slot_q <= in_slot;
      now_q  <= in_time & 48'((64'd1 << TW) - 64'd1);
    end
  end

  assign addr = cmd.use_walk ? walk[AW-1:0] : slot_q[AW-1:0];

  assign iv  = (now_q - stamp_rd) & 48'((64'd1 << TW) - 64'd1);
  assign sum = {1'b0, tot_rd} + {9'd0, iv};

  always_comb begin
    we_stamp = cmd.wr_begin || cmd.clr;
    stamp_wd = cmd.wr_begin ? now_q : '0;
    we_stat  = cmd.upd_end || cmd.clr || (cmd.wr_begin && new_slot);
    min_wd = '0;
    max_wd = '0;
    tot_wd = '0;
    cnt_wd = '0;
    if (cmd.upd_end) begin
      min_wd = (cnt_rd == '0 || iv < min_rd) ? iv : min_rd;
      max_wd = (cnt_rd == '0 || iv > max_rd) ? iv : max_rd;
      tot_wd = sum[56] ? TOT_MAX : sum[55:0];
      cnt_wd = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 32'd1;
    end
  end

  its_ram #(.WIDTH(48), .DEPTH(NUM_SLOTS)) u_stamp (.clk, .we(we_stamp), .waddr(addr),
    .wdata(stamp_wd), .raddr(addr), .rdata(stamp_rd));
  its_ram #(.WIDTH(48), .DEPTH(NUM_SLOTS)) u_min (.clk, .we(we_stat), .waddr(addr),
    .wdata(min_wd), .raddr(addr), .rdata(min_rd));
  its_ram #(.WIDTH(48), .DEPTH(NUM_SLOTS)) u_max (.clk, .we(we_stat), .waddr(addr),
    .wdata(max_wd), .raddr(addr), .rdata(max_rd));
  its_ram #(.WIDTH(56), .DEPTH(NUM_SLOTS)) u_tot (.clk, .we(we_stat), .waddr(addr),
    .wdata(tot_wd), .raddr(addr), .rdata(tot_rd));
  its_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_cnt (.clk, .we(we_stat), .waddr(addr),
    .wdata(cnt_wd), .raddr(addr), .rdata(cnt_rd));

  its_div u_div (.clk, .rst, .start(cmd.div_start), .dividend(tot_rd), .divisor(cnt_rd),
    .quotient(quo), .done(div_done));

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_last   <= cmd.res_last;
      if (cmd.res_status == ST_RECORD) begin
        res_slot  <= walk;
        res_count <= cnt_rd;
        res_total <= tot_rd;
        res_min   <= min_rd;
        res_max   <= max_rd;
        res_avg   <= quo;
      end else begin
        res_slot  <= (cmd.res_status == ST_EMPTY) ? 6'd0 : slot_q;
        res_count <= '0;
        res_total <= '0;
        res_min   <= '0;
        res_max   <= '0;
        res_avg   <= '0;
      end
    end
  end
endmodule

// File: hw/rtl/its_ctrl.sv
// ----------------------------------------------------------------------------
// its_ctrl
// Controller: sequences begin, end and report items over the datapath.
// ----------------------------------------------------------------------------
module its_ctrl #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [5:0]        in_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output its_pkg::its_cmd_t cmd,
  input  its_pkg::its_sts_t sts,
  output logic              new_slot,
  output logic [5:0]        walk
);
  import its_pkg::*;
  typedef enum logic [2:0] {IDLE, RD, EXEC, RPT_RD, RPT_DIV, RPT_CLR, RPT_OUT, OUT} state_t;

  state_t     state;
  logic [6:0] used;
  logic [1:0] kind_q;
  logic [5:0] slot_q;
  logic       accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == IDLE);
  assign new_slot = ({1'b0, slot_q} == used);

  always_comb begin
    cmd = '0;
    cmd.load_in = accept;
    unique case (state)
      RD: cmd.rd = 1'b1;
      EXEC: begin
        cmd.set_res = 1'b1;
        cmd.res_last = 1'b1;
        if (kind_q == KIND_BEGIN) begin
          if ({1'b0, slot_q} > used || {1'b0, slot_q} >= 7'(NUM_SLOTS)) begin
            cmd.res_status = ST_BAD_BEGIN;
          end else begin
            cmd.res_status = ST_OK;
            cmd.wr_begin = 1'b1;
          end
        end else if ({1'b0, slot_q} >= used) begin
          cmd.res_status = ST_BAD_END;
        end else begin
          cmd.res_status = ST_OK;
          cmd.upd_end = 1'b1;
        end
      end
      RPT_RD: cmd.use_walk = 1'b1;
      RPT_DIV: begin
        cmd.use_walk = 1'b1;
        cmd.div_start = 1'b1;
      end
      RPT_CLR: begin
        cmd.use_walk = 1'b1;
        if (sts.div_done) begin
          cmd.set_res = 1'b1;
          cmd.res_status = ST_RECORD;
          cmd.res_last = ({1'b0, walk} + 7'd1 == used);
          cmd.clr = 1'b1;
        end
      end
      OUT: begin
        // Only a report with no slots arrives here with the result not yet set.
        if (!out_valid) begin
          cmd.set_res = 1'b1;
          cmd.res_status = ST_EMPTY;
          cmd.res_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      walk      <= '0;
    end else begin
      unique case (state)
        IDLE: if (accept) begin
          kind_q <= in_kind;
          slot_q <= in_slot;
          if (in_kind == KIND_BEGIN || in_kind == KIND_END) state <= RD;
          else if (in_kind == KIND_REPORT) begin
            walk <= '0;
            if (used == '0) state <= OUT;
            else state <= RPT_RD;
          end
        end
        RD: state <= EXEC;
        EXEC: begin
          if (kind_q == KIND_BEGIN && new_slot && {1'b0, slot_q} < 7'(NUM_SLOTS))
            used <= used + 7'd1;
          out_valid <= 1'b1;
          state <= OUT;
        end
        RPT_RD: state <= RPT_DIV;
        RPT_DIV: state <= RPT_CLR;
        RPT_CLR: if (sts.div_done) begin
          out_valid <= 1'b1;
          state <= RPT_OUT;
        end
        RPT_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if ({1'b0, walk} + 7'd1 == used) state <= IDLE;
          else begin
            walk  <= walk + 6'd1;
            state <= RPT_RD;
          end
        end
        OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/interval_timing_statistics.sv
// Begin or end: an accepted item passes the RD and EXEC states, then OUT presents its result.
// Items do not overlap: in_ready is high only in IDLE, so a new item waits for the slot RAM
// read-modify-write and the transfer of the single result register.
// Report: each created slot passes RPT_RD, RPT_DIV, RPT_CLR, which waits for the 56-bit
// one-bit-per-cycle divider, and RPT_OUT; a report with no slots latches its result in OUT.
// Reset: rst clears the slot count and control; slot RAMs are written when a slot is created.
// ----------------------------------------------------------------------------
// interval_timing_statistics
// Per-slot interval min, max, total, count and average collection.
// ----------------------------------------------------------------------------
module interval_timing_statistics #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 48
) (
  input logic clk,
  input logic rst,
  its_in_if.sink   in_ch,
  its_out_if.source out_ch
);
  import its_pkg::*;
  its_cmd_t   cmd;
  its_sts_t   sts;
  logic       new_slot;
  logic [5:0] walk;
  logic [2:0] st_tmp;

  its_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
    .in_slot(in_ch.slot), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts, .new_slot, .walk);

  its_datapath #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .in_slot(in_ch.slot), .in_time(in_ch.time_now),
    .new_slot, .walk, .res_status(st_tmp), .res_slot(out_ch.slot_out),
    .res_count(out_ch.interval_count), .res_total(out_ch.total_ns),
    .res_min(out_ch.min_ns), .res_max(out_ch.max_ns), .res_avg(out_ch.avg_ns),
    .res_last(out_ch.last));

  assign out_ch.status = st_tmp;
endmodule

// File: hw/rtl/its_checker.sv
// ----------------------------------------------------------------------------
// its_checker
// Port-level checks for the interval timing statistics block.
// ----------------------------------------------------------------------------
`include "interval_timing_statistics_defines.svh"
module its_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       last
);
  import its_pkg::*;
  `ITS_ASSERT_IMPL(a_busy, clk, rst, out_valid, !in_ready)
  `ITS_ASSERT_IMPL(a_last, clk, rst, out_valid && status != ST_RECORD, last)
  `ITS_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `ITS_ASSERT_NEXT(a_gap, clk, rst, in_valid && in_ready && (kind == KIND_BEGIN || kind == KIND_END || kind == KIND_REPORT), !in_ready)
endmodule

bind interval_timing_statistics its_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .kind(in_ch.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .last(out_ch.last));

// File: verif/interval_timing_statistics_test.sv
// ----------------------------------------------------------------------------
// interval_timing_statistics_test
// Drives begin, end and report events into the interval statistics table and
// checks every result against the slot-table predictor or a typed-in result.
// ----------------------------------------------------------------------------
module interval_timing_statistics_test;
  import its_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 16;
  localparam logic [55:0] TOTAL_SAT = {56{1'b1}};
  localparam logic [31:0] COUNT_SAT = {32{1'b1}};
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] interval_count;
    logic [55:0] total_ns;
    logic [47:0] min_ns;
    logic [47:0] max_ns;
    logic [55:0] avg_ns;
    logic        last;
  } stat_rec_t;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [47:0] time_now;
    bit          typed;
    stat_rec_t   rec;
  } event_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int errors = 0;

  its_in_if in_ch();
  its_out_if out_ch();

  interval_timing_statistics dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  int unsigned created;
  logic [47:0] stamp_m [NSLOTS];
  logic [55:0] total_m [NSLOTS];
  logic [47:0] min_m [NSLOTS];
  logic [47:0] max_m [NSLOTS];
  logic [31:0] count_m [NSLOTS];
  stat_rec_t expected_recs[$];

  function automatic stat_rec_t simple_rec(logic [2:0] st, logic [5:0] s);
    stat_rec_t r;
    r = '0;
    r.status = st;
    r.slot_out = s;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic clear_stats(int i);
    stamp_m[i] = '0;
    total_m[i] = '0;
    min_m[i] = '0;
    max_m[i] = '0;
    count_m[i] = '0;
  endtask

  task automatic predict_stats(logic [1:0] kind, logic [5:0] s, logic [47:0] t);
    logic [47:0] iv;
    logic [56:0] sum;
    stat_rec_t r;
    if (kind == KIND_BEGIN) begin
      if (s > created || s >= NSLOTS) begin
        expected_recs.push_back(simple_rec(ST_BAD_BEGIN, s));
      end else begin
        if (s == created) begin
          clear_stats(s);
          created++;
        end
        stamp_m[s] = t;
        expected_recs.push_back(simple_rec(ST_OK, s));
      end
    end else if (kind == KIND_END) begin
      if (s >= created) begin
        expected_recs.push_back(simple_rec(ST_BAD_END, s));
      end else begin
        iv = t - stamp_m[s];
        if (count_m[s] == 0) begin
          min_m[s] = iv;
          max_m[s] = iv;
        end else begin
          if (iv < min_m[s]) min_m[s] = iv;
          if (iv > max_m[s]) max_m[s] = iv;
        end
        sum = {1'b0, total_m[s]} + {9'd0, iv};
        total_m[s] = (sum >= {1'b0, TOTAL_SAT}) ? TOTAL_SAT : sum[55:0];
        if (count_m[s] != COUNT_SAT) count_m[s]++;
        expected_recs.push_back(simple_rec(ST_OK, s));
      end
    end else if (kind == KIND_REPORT) begin
      if (created == 0) begin
        expected_recs.push_back(simple_rec(ST_EMPTY, 6'd0));
      end else begin
        for (int i = 0; i < created; i++) begin
          r.status = ST_RECORD;
          r.slot_out = 6'(i);
          r.interval_count = count_m[i];
          r.total_ns = total_m[i];
          r.min_ns = min_m[i];
          r.max_ns = max_m[i];
          r.avg_ns = (count_m[i] != 0) ? total_m[i] / count_m[i] : '0;
          r.last = (i + 1 == created);
          expected_recs.push_back(r);
          clear_stats(i);
        end
      end
    end
  endtask

  // Sender: bursts and gaps.
  event_row_t pending[$];
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.slot <= '0;
      in_ch.time_now <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_stats(in_ch.kind, in_ch.slot, in_ch.time_now);
        // A row with a typed-in result is checked against that result.
        if (pending[0].typed) expected_recs[$] = pending[0].rec;
        void'(pending.pop_front());
      end
      if (pending.size() != 0 && !(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0 && !(in_ch.valid && in_ch.ready && burst_left > 0)) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.kind <= pending[0].kind;
          in_ch.slot <= pending[0].slot;
          in_ch.time_now <= pending[0].time_now;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else if (pending.size() == 0) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_rec(stat_rec_t e);
    if (out_ch.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, out_ch.status); errors++;
    end
    if (out_ch.slot_out !== e.slot_out) begin
      $error("slot_out: expected %0d actual %0d", e.slot_out, out_ch.slot_out); errors++;
    end
    if (out_ch.interval_count !== e.interval_count) begin
      $error("interval_count: expected %0d actual %0d", e.interval_count,
             out_ch.interval_count); errors++;
    end
    if (out_ch.total_ns !== e.total_ns) begin
      $error("total_ns: expected %0d actual %0d", e.total_ns, out_ch.total_ns); errors++;
    end
    if (out_ch.min_ns !== e.min_ns) begin
      $error("min_ns: expected %0d actual %0d", e.min_ns, out_ch.min_ns); errors++;
    end
    if (out_ch.max_ns !== e.max_ns) begin
      $error("max_ns: expected %0d actual %0d", e.max_ns, out_ch.max_ns); errors++;
    end
    if (out_ch.avg_ns !== e.avg_ns) begin
      $error("avg_ns: expected %0d actual %0d", e.avg_ns, out_ch.avg_ns); errors++;
    end
    if (out_ch.last !== e.last) begin
      $error("last: expected %0d actual %0d", e.last, out_ch.last); errors++;
    end
  endtask

  // Receiver: stalls in its own rhythm, checks each transfer.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_phase[8]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_recs.size() == 0) begin
          $error("result with nothing expected: status %0d slot %0d",
                 out_ch.status, out_ch.slot_out);
          errors++;
        end else begin
          check_rec(expected_recs.pop_front());
        end
      end
    end
  end

  function automatic event_row_t ev(logic [1:0] k, logic [5:0] s, logic [47:0] t);
    event_row_t r;
    r.kind = k;
    r.slot = s;
    r.time_now = t;
    r.typed = 1'b0;
    r.rec = '0;
    return r;
  endfunction

  function automatic event_row_t ev_typed(logic [1:0] k, logic [5:0] s, logic [47:0] t,
                                          stat_rec_t rec);
    event_row_t r;
    r = ev(k, s, t);
    r.typed = 1'b1;
    r.rec = rec;
    return r;
  endfunction

  task automatic add_events();
    event_row_t directed[$];
    int ncreated;
    logic [47:0] clock_ns;
    int r;
    logic [5:0] s;
    // Directed table.
    directed = '{
      ev_typed(KIND_REPORT, 6'd0, 48'd0, simple_rec(ST_EMPTY, 6'd0)),
      ev_typed(KIND_END, 6'd0, 48'd5, simple_rec(ST_BAD_END, 6'd0)),
      ev_typed(KIND_BEGIN, 6'd63, 48'd0, simple_rec(ST_BAD_BEGIN, 6'd63)),
      ev_typed(KIND_BEGIN, 6'd1, 48'd0, simple_rec(ST_BAD_BEGIN, 6'd1)),
      ev(KIND_UNUSED, 6'd0, 48'd0),
      ev_typed(KIND_BEGIN, 6'd0, {48{1'b1}}, simple_rec(ST_OK, 6'd0)),
      ev(KIND_END, 6'd0, 48'd9),
      ev(KIND_END, 6'd0, 48'd3),
      ev(KIND_BEGIN, 6'd1, 48'd0),
      ev(KIND_END, 6'd1, {48{1'b1}}),
      ev(KIND_BEGIN, 6'd1, 48'd100),
      ev(KIND_END, 6'd1, 48'd50),
      ev(KIND_END, 6'd1, 48'd150),
      ev_typed(KIND_END, 6'd2, 48'd7, simple_rec(ST_BAD_END, 6'd2)),
      ev(KIND_BEGIN, 6'd2, 48'd42),
      ev(KIND_REPORT, 6'd21, 48'hAAAA_AAAA_AAAA),
      ev(KIND_END, 6'd0, 48'h5555_5555_5555),
      ev(KIND_REPORT, 6'd0, 48'd0)
    };
    foreach (directed[i]) pending.push_back(directed[i]);
    // Fill every slot, including the full-table case, then total saturation
    // through many maximal intervals on slot 0 measured from one stamp.
    for (int i = 3; i < NSLOTS; i++) pending.push_back(ev(KIND_BEGIN, 6'(i), 48'($urandom())));
    pending.push_back(ev(KIND_BEGIN, 6'd16, 48'd0));
    pending.push_back(ev(KIND_BEGIN, 6'd0, 48'd1));
    for (int i = 0; i < 257; i++) pending.push_back(ev(KIND_END, 6'd0, 48'd0));
    pending.push_back(ev(KIND_REPORT, 6'd0, 48'd0));
    // Random: mostly begin and end events on random slots, with time advancing.
    ncreated = NSLOTS;
    clock_ns = 48'({$urandom(), $urandom()});
    for (int i = 0; i < 150; i++) begin
      r = $urandom_range(0, 99);
      clock_ns = 48'(clock_ns + (($urandom_range(0, 7) == 0) ? {$urandom(), $urandom()}
                                                             : 64'($urandom_range(0, 5000))));
      if (r < 45) s = 6'($urandom_range(0, NSLOTS - 1));
      else s = 6'($urandom_range(0, 63));
      if (r < 3) begin
        pending.push_back(ev(KIND_REPORT, 6'($urandom()), 48'({$urandom(), $urandom()})));
      end else if (r < 5) begin
        pending.push_back(ev(KIND_UNUSED, 6'($urandom()), 48'($urandom())));
      end else if (r < 55) begin
        pending.push_back(ev(KIND_BEGIN, s, clock_ns));
      end else begin
        pending.push_back(ev(KIND_END, s, clock_ns));
      end
    end
    pending.push_back(ev(KIND_REPORT, 6'd0, 48'd0));
  endtask

  initial begin
    created = 0;
    for (int i = 0; i < NSLOTS; i++) clear_stats(i);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    add_events();
    while (pending.size() != 0) @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
